// File: rtl/pwfp_pkg.sv
// Package: shared types, codes and sizes for the protobuf wire field parser.
`timescale 1ns / 1ps
package pwfp_pkg;

   localparam int FIELD_NUM_BITS    = 29;
   localparam int VARINT_MAX_BYTES  = 10;
   localparam int QUEUE_DEPTH       = 4;
   localparam int QPTR_BITS         = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS         = $clog2(QUEUE_DEPTH + 1);

   localparam logic [2:0] WIRE_VARINT      = 3'd0;
   localparam logic [2:0] WIRE_FIXED64     = 3'd1;
   localparam logic [2:0] WIRE_LEN         = 3'd2;
   localparam logic [2:0] WIRE_GROUP_START = 3'd3;
   localparam logic [2:0] WIRE_GROUP_END   = 3'd4;
   localparam logic [2:0] WIRE_FIXED32     = 3'd5;

   typedef enum logic [2:0] {
      PH_TAG,
      PH_VALUE,
      PH_FIXED,
      PH_LEN,
      PH_PAYLOAD,
      PH_DISCARD
   } phase_type;

   typedef enum logic [1:0] {
      KIND_FIELD   = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_ERROR   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ERR_OVERLONG  = 2'd0,
      ERR_BAD_TAG   = 2'd1,
      ERR_GROUP     = 2'd2,
      ERR_TRUNCATED = 2'd3
   } err_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       last_byte;
   } req_item_type;

   typedef struct packed {
      kind_type    result_kind;
      logic [28:0] field_number;
      logic [2:0]  wire_type;
      logic [63:0] field_value;
      logic [7:0]  payload_byte;
      logic        payload_last;
      err_type     error_code;
      logic        message_end;
   } rsp_item_type;

   // Compact result record between front and back
   typedef struct packed {
      kind_type    kind;
      logic [28:0] field;
      logic [2:0]  wtype;
      logic [63:0] data;
      logic        plast;
      err_type     code;
      logic        mend;
   } rec_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

endpackage

// File: rtl/pwfp_front.sv
// Front end: per-byte wire format decoder that turns completed fields, payload bytes and errors into result records.
`timescale 1ns / 1ps
module pwfp_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  pwfp_pkg::req_item_type req_item,
   output logic                  rec_valid,
   output pwfp_pkg::rec_type     rec
);

   pwfp_pkg::phase_type phase_ff, phase_in;
   logic [3:0]  gc_ff, gc_in;
   logic [63:0] acc_ff, acc_in;
   logic [2:0]  fi_ff, fi_in;
   logic [28:0] field_ff, field_in;
   logic [2:0]  wire_ff, wire_in;
   logic [63:0] pr_ff, pr_in;

   logic [7:0]  b;
   logic        last;
   logic        vi_over, vi_more, vi_done;
   logic [6:0]  sh7;
   logic [63:0] acc_vi, acc_fx, pr_dec;
   logic        fx_done, pay_done;
   logic        tag_zero, tag_big, tag_ok;
   logic [2:0]  tag_wire;
   logic        err;
   pwfp_pkg::err_type err_code;

   assign b    = req_item.in_byte;
   assign last = req_item.last_byte;

   assign vi_over = (gc_ff >= 4'(pwfp_pkg::VARINT_MAX_BYTES));
   assign vi_more = !vi_over && b[7];
   assign vi_done = !vi_over && !b[7];

   // seven bits per varint group; on the tenth group only bit 0 survives
   assign sh7    = {gc_ff, 3'b000} - {3'b000, gc_ff};
   assign acc_vi = acc_ff | ({57'd0, b[6:0]} << sh7[5:0]);
   assign acc_fx = acc_ff | ({56'd0, b} << {fi_ff, 3'b000});

   assign fx_done  = (wire_ff == pwfp_pkg::WIRE_FIXED64) ? (fi_ff == 3'd7) : (fi_ff >= 3'd3);
   assign pr_dec   = (pr_ff == 64'd0) ? 64'd0 : pr_ff - 64'd1;
   assign pay_done = (pr_dec == 64'd0);

   assign tag_zero = (acc_vi[63:3] == 61'd0);
   assign tag_big  = |acc_vi[63:3 + pwfp_pkg::FIELD_NUM_BITS];
   assign tag_wire = acc_vi[2:0];
   assign tag_ok   = (phase_ff == pwfp_pkg::PH_TAG) && vi_done && !tag_zero && !tag_big &&
                     (tag_wire != pwfp_pkg::WIRE_GROUP_START) &&
                     (tag_wire != pwfp_pkg::WIRE_GROUP_END) &&
                     (tag_wire <= pwfp_pkg::WIRE_FIXED32);

   // Output decode
   always_comb begin
      rec_valid = 1'b0;
      err       = 1'b0;
      err_code  = pwfp_pkg::ERR_OVERLONG;
      rec.kind  = pwfp_pkg::KIND_FIELD;
      rec.field = field_ff;
      rec.wtype = wire_ff;
      rec.data  = acc_vi;
      rec.plast = 1'b0;
      rec.mend  = last;
      case (phase_ff)
         pwfp_pkg::PH_TAG: begin
            if (vi_over) begin
               err = 1'b1;
            end else if (vi_more) begin
               if (last) begin
                  err      = 1'b1;
                  err_code = pwfp_pkg::ERR_TRUNCATED;
               end
            end else if (tag_zero || tag_big) begin
               err      = 1'b1;
               err_code = pwfp_pkg::ERR_BAD_TAG;
            end else if (tag_wire == pwfp_pkg::WIRE_GROUP_START ||
                         tag_wire == pwfp_pkg::WIRE_GROUP_END) begin
               err      = 1'b1;
               err_code = pwfp_pkg::ERR_GROUP;
            end else if (tag_wire > pwfp_pkg::WIRE_FIXED32) begin
               err      = 1'b1;
               err_code = pwfp_pkg::ERR_BAD_TAG;
            end else if (last) begin
               err      = 1'b1;
               err_code = pwfp_pkg::ERR_TRUNCATED;
            end
         end
         pwfp_pkg::PH_VALUE: begin
            if (vi_over) begin
               err = 1'b1;
            end else if (vi_more) begin
               if (last) begin
                  err      = 1'b1;
                  err_code = pwfp_pkg::ERR_TRUNCATED;
               end
            end else begin
               rec_valid = 1'b1;
            end
         end
         pwfp_pkg::PH_LEN: begin
            if (vi_over) begin
               err = 1'b1;
            end else if (vi_more) begin
               if (last) begin
                  err      = 1'b1;
                  err_code = pwfp_pkg::ERR_TRUNCATED;
               end
            end else if (acc_vi != 64'd0 && last) begin
               err      = 1'b1;
               err_code = pwfp_pkg::ERR_TRUNCATED;
            end else begin
               rec_valid = 1'b1;
            end
         end
         pwfp_pkg::PH_FIXED: begin
            rec.data = acc_fx;
            if (fx_done) begin
               rec_valid = 1'b1;
            end else if (last) begin
               err      = 1'b1;
               err_code = pwfp_pkg::ERR_TRUNCATED;
            end
         end
         pwfp_pkg::PH_PAYLOAD: begin
            if (!pay_done && last) begin
               err      = 1'b1;
               err_code = pwfp_pkg::ERR_TRUNCATED;
            end else begin
               rec_valid = 1'b1;
               rec.kind  = pwfp_pkg::KIND_PAYLOAD;
               rec.data  = {56'd0, b};
               rec.plast = pay_done;
            end
         end
         default: begin
            rec_valid = 1'b0;
         end
      endcase
      if (err) begin
         rec_valid = 1'b1;
         rec.kind  = pwfp_pkg::KIND_ERROR;
      end
      rec.code = err_code;
   end

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (err) begin
         phase_in = last ? pwfp_pkg::PH_TAG : pwfp_pkg::PH_DISCARD;
      end else begin
         case (phase_ff)
            pwfp_pkg::PH_TAG: begin
               if (vi_done) begin
                  case (tag_wire)
                     pwfp_pkg::WIRE_VARINT: phase_in = pwfp_pkg::PH_VALUE;
                     pwfp_pkg::WIRE_LEN:    phase_in = pwfp_pkg::PH_LEN;
                     default:               phase_in = pwfp_pkg::PH_FIXED;
                  endcase
               end
            end
            pwfp_pkg::PH_VALUE: begin
               if (vi_done) phase_in = pwfp_pkg::PH_TAG;
            end
            pwfp_pkg::PH_LEN: begin
               if (vi_done) begin
                  phase_in = (acc_vi == 64'd0) ? pwfp_pkg::PH_TAG : pwfp_pkg::PH_PAYLOAD;
               end
            end
            pwfp_pkg::PH_FIXED: begin
               if (fx_done) phase_in = pwfp_pkg::PH_TAG;
            end
            pwfp_pkg::PH_PAYLOAD: begin
               if (pay_done) phase_in = pwfp_pkg::PH_TAG;
            end
            pwfp_pkg::PH_DISCARD: begin
               if (last) phase_in = pwfp_pkg::PH_TAG;
            end
            default: begin
               phase_in = pwfp_pkg::PH_TAG;
            end
         endcase
      end
   end

   // Working registers
   always_comb begin
      gc_in    = gc_ff;
      acc_in   = acc_ff;
      fi_in    = fi_ff;
      pr_in    = pr_ff;
      field_in = field_ff;
      wire_in  = wire_ff;
      if (tag_ok) begin
         field_in = acc_vi[31:3];
         wire_in  = tag_wire;
      end
      if (err) begin
         gc_in  = 4'd0;
         acc_in = 64'd0;
         fi_in  = 3'd0;
         pr_in  = 64'd0;
      end else begin
         case (phase_ff)
            pwfp_pkg::PH_TAG, pwfp_pkg::PH_VALUE, pwfp_pkg::PH_LEN: begin
               if (vi_more) begin
                  gc_in  = gc_ff + 4'd1;
                  acc_in = acc_vi;
               end else if (vi_done) begin
                  gc_in  = 4'd0;
                  acc_in = 64'd0;
                  fi_in  = 3'd0;
                  if (phase_ff == pwfp_pkg::PH_LEN) pr_in = acc_vi;
               end
            end
            pwfp_pkg::PH_FIXED: begin
               if (fx_done) begin
                  gc_in  = 4'd0;
                  acc_in = 64'd0;
                  fi_in  = 3'd0;
               end else begin
                  fi_in  = fi_ff + 3'd1;
                  acc_in = acc_fx;
               end
            end
            pwfp_pkg::PH_PAYLOAD: begin
               pr_in = pr_dec;
            end
            default: begin
               if (last) begin
                  gc_in  = 4'd0;
                  acc_in = 64'd0;
                  fi_in  = 3'd0;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= pwfp_pkg::PH_TAG;
         gc_ff    <= 4'd0;
         acc_ff   <= 64'd0;
         fi_ff    <= 3'd0;
         field_ff <= 29'd0;
         wire_ff  <= 3'd0;
         pr_ff    <= 64'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         gc_ff    <= gc_in;
         acc_ff   <= acc_in;
         fi_ff    <= fi_in;
         field_ff <= field_in;
         wire_ff  <= wire_in;
         pr_ff    <= pr_in;
      end
   end

   a_last_to_tag: assert property (@(posedge clock) disable iff (reset)
      accept && last |=> phase_ff == pwfp_pkg::PH_TAG)
      else $error("phase not back at tag after end of message");

   a_err_discard: assert property (@(posedge clock) disable iff (reset)
      accept && err && !last |=> phase_ff == pwfp_pkg::PH_DISCARD)
      else $error("error not followed by discard");

   a_gc_bound: assert property (@(posedge clock) disable iff (reset)
      gc_ff <= 4'(pwfp_pkg::VARINT_MAX_BYTES))
      else $error("varint group count out of range");

   a_payload_len: assert property (@(posedge clock) disable iff (reset)
      phase_ff == pwfp_pkg::PH_PAYLOAD |-> pr_ff != 64'd0)
      else $error("payload phase with nothing left");

endmodule

// File: rtl/pwfp_queue.sv
// Short register queue of result records between front and back.
`timescale 1ns / 1ps
module pwfp_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  pwfp_pkg::rec_type       push_rec,
   input  logic                    pop,
   output pwfp_pkg::rec_type       head_rec,
   output pwfp_pkg::q_status_type  status
);

   pwfp_pkg::rec_type entry_ff [pwfp_pkg::QUEUE_DEPTH];
   logic [pwfp_pkg::QPTR_BITS-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [pwfp_pkg::QCNT_BITS-1:0] cnt_ff, cnt_in;
   logic do_push, do_pop;

   assign status.empty = (cnt_ff == '0);
   assign status.full  = (cnt_ff == pwfp_pkg::QCNT_BITS'(pwfp_pkg::QUEUE_DEPTH));
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_rec     = entry_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == pwfp_pkg::QPTR_BITS'(pwfp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == pwfp_pkg::QPTR_BITS'(pwfp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) cnt_in = cnt_ff + 1'b1;
      if (do_pop && !do_push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ff] <= push_rec;
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= pwfp_pkg::QCNT_BITS'(pwfp_pkg::QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      do_push && !do_pop |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("queue count did not advance on push");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      status.empty |-> wr_ff == rd_ff)
      else $error("empty queue with pointers apart");

endmodule

// File: rtl/pwfp_back.sv
// Back end: expands queued records into result items and holds them in the output register.
`timescale 1ns / 1ps
module pwfp_back (
   input  logic                   clock,
   input  logic                   reset,
   input  pwfp_pkg::rec_type      head_rec,
   input  logic                   head_valid,
   output logic                   head_take,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output pwfp_pkg::rsp_item_type rsp_item
);

   logic                   out_valid_ff, out_valid_in;
   pwfp_pkg::rsp_item_type out_ff, out_in;

   assign head_take = head_valid && (!out_valid_ff || rsp_pop);
   assign rsp_empty = !out_valid_ff;
   assign rsp_item  = out_ff;

   // Zero every field that the kind does not use
   always_comb begin
      out_in.result_kind  = head_rec.kind;
      out_in.field_number = head_rec.field;
      out_in.wire_type    = head_rec.wtype;
      out_in.field_value  = 64'd0;
      out_in.payload_byte = 8'd0;
      out_in.payload_last = 1'b0;
      out_in.error_code   = pwfp_pkg::ERR_OVERLONG;
      out_in.message_end  = head_rec.mend;
      case (head_rec.kind)
         pwfp_pkg::KIND_FIELD: begin
            out_in.field_value = head_rec.data;
         end
         pwfp_pkg::KIND_PAYLOAD: begin
            out_in.payload_byte = head_rec.data[7:0];
            out_in.payload_last = head_rec.plast;
         end
         default: begin
            out_in.field_number = 29'd0;
            out_in.wire_type    = 3'd0;
            out_in.error_code   = head_rec.code;
         end
      endcase
      out_valid_in = head_take || (out_valid_ff && !rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (head_take) out_ff <= out_in;
   end

endmodule

// File: rtl/protobuf_wire_field_parser_core.sv
// Top level: protobuf wire format field parser, front decoder, record queue and output stage.
//
//  channel  ports                          direction  item
//  request  req_push req_full req_item     in         one message byte and end mark
//  response rsp_empty rsp_pop rsp_item     out        field, payload byte or error
//
// Each byte is decoded in the cycle it is accepted; one byte per cycle sustained while the record queue is not full.
// A result reaches rsp_item through the queue entry and then the output register.
// req_full rises only when the four-entry record queue is full, i.e. after the
// consumer has held off rsp_pop.
// Synchronous active-high reset empties queue and output register and sets the
// decoder to expect a tag; no clearing pass is needed.
`timescale 1ns / 1ps
module protobuf_wire_field_parser_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  pwfp_pkg::req_item_type req_item,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output pwfp_pkg::rsp_item_type rsp_item
);

   logic                   accept;
   logic                   rec_valid;
   pwfp_pkg::rec_type      rec;
   pwfp_pkg::rec_type      head_rec;
   pwfp_pkg::q_status_type q_status;
   logic                   head_take;

   assign req_full = q_status.full;
   assign accept   = req_push && !q_status.full;

   pwfp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_item  (req_item),
      .rec_valid (rec_valid),
      .rec       (rec)
   );

   pwfp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (accept && rec_valid),
      .push_rec (rec),
      .pop      (head_take),
      .head_rec (head_rec),
      .status   (q_status)
   );

   pwfp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_rec   (head_rec),
      .head_valid (!q_status.empty),
      .head_take  (head_take),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_item   (rsp_item)
   );

endmodule

// File: sim/protobuf_wire_field_parser_core_test.sv
// Self-checking test of the protobuf wire field parser: streamed messages against a decoder model.
`timescale 1ns / 1ps
module protobuf_wire_field_parser_core_test;

   localparam logic [60:0] FIELD_NUMBER_MAX = (61'd1 << pwfp_pkg::FIELD_NUM_BITS) - 61'd1;
   localparam logic [2:0]  WIRE_RESERVED7   = 3'd7;
   localparam int          HOLD_CYCLES      = 80;
   localparam int          QUIET_LIMIT      = 2000;
   localparam int          PHASE_BYTES      = 225;
   localparam int          SETTLE_CYCLES    = 10;

   typedef enum {VARINT_MORE, VARINT_DONE, VARINT_OVER} varint_step_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_push = 1'b0;
   logic                   req_full;
   pwfp_pkg::req_item_type req_item = '0;
   logic                   rsp_empty;
   logic                   rsp_pop = 1'b0;
   pwfp_pkg::rsp_item_type rsp_item;

   // decoder state mirrored by the predictor
   pwfp_pkg::phase_type dec_phase = pwfp_pkg::PH_TAG;
   int unsigned dec_groups = 0;
   logic [63:0] dec_acc = '0;
   logic [28:0] dec_field = '0;
   logic [2:0]  dec_wire = '0;
   int unsigned dec_fix = 0;
   logic [63:0] dec_left = '0;

   pwfp_pkg::rsp_item_type predicted_results[$];
   pwfp_pkg::req_item_type tx_bytes[$];
   logic [7:0]             msg_bytes[$];

   int unsigned bytes_queued = 0;
   int unsigned bytes_accepted = 0;
   int unsigned fields_seen = 0;
   int unsigned payload_seen = 0;
   int unsigned errors_seen = 0;
   int unsigned full_cycles = 0;
   int unsigned fail_count = 0;
   int unsigned quiet_cycles = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   bit          hold_request = 1'b0;
   bit          hold_started = 1'b0;
   int unsigned hold_left = 0;

   protobuf_wire_field_parser_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_item  (req_item),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

   always #10 clock = ~clock;

   // ---------------- decoder model ----------------

   function automatic void clear_work();
      dec_groups = 0;
      dec_acc = '0;
      dec_fix = 0;
   endfunction

   function automatic varint_step_type take_varint_group(input logic [7:0] b);
      if (dec_groups >= pwfp_pkg::VARINT_MAX_BYTES) return VARINT_OVER;
      dec_acc |= {57'd0, b[6:0]} << (7 * dec_groups);
      if (!b[7]) return VARINT_DONE;
      dec_groups++;
      return VARINT_MORE;
   endfunction

   task automatic push_error(input pwfp_pkg::err_type code, input bit last);
      pwfp_pkg::rsp_item_type r;
      r = '0;
      r.result_kind = pwfp_pkg::KIND_ERROR;
      r.error_code = code;
      r.message_end = last;
      predicted_results.push_back(r);
      clear_work();
      dec_left = '0;
      // an error mid-message drops everything up to the end mark
      dec_phase = last ? pwfp_pkg::PH_TAG : pwfp_pkg::PH_DISCARD;
   endtask

   task automatic push_field(input logic [63:0] value, input bit last);
      pwfp_pkg::rsp_item_type r;
      r = '0;
      r.result_kind = pwfp_pkg::KIND_FIELD;
      r.field_number = dec_field;
      r.wire_type = dec_wire;
      r.field_value = value;
      r.message_end = last;
      predicted_results.push_back(r);
   endtask

   task automatic decode_byte(input logic [7:0] b, input bit last);
      varint_step_type        step;
      pwfp_pkg::rsp_item_type r;
      logic [60:0]            number;
      logic [2:0]             wtype;
      int unsigned            need;
      case (dec_phase)
         pwfp_pkg::PH_DISCARD: begin
            if (last) begin
               dec_phase = pwfp_pkg::PH_TAG;
               clear_work();
            end
         end
         pwfp_pkg::PH_VALUE: begin
            step = take_varint_group(b);
            if (step == VARINT_OVER) push_error(pwfp_pkg::ERR_OVERLONG, last);
            else if (step == VARINT_MORE) begin
               if (last) push_error(pwfp_pkg::ERR_TRUNCATED, last);
            end else begin
               push_field(dec_acc, last);
               clear_work();
               dec_phase = pwfp_pkg::PH_TAG;
            end
         end
         pwfp_pkg::PH_LEN: begin
            step = take_varint_group(b);
            if (step == VARINT_OVER) push_error(pwfp_pkg::ERR_OVERLONG, last);
            else if (step == VARINT_MORE) begin
               if (last) push_error(pwfp_pkg::ERR_TRUNCATED, last);
            end else if (dec_acc == 0) begin
               push_field('0, last);
               clear_work();
               dec_phase = pwfp_pkg::PH_TAG;
            end else if (last) begin
               push_error(pwfp_pkg::ERR_TRUNCATED, last);
            end else begin
               dec_left = dec_acc;
               push_field(dec_acc, 1'b0);
               clear_work();
               dec_phase = pwfp_pkg::PH_PAYLOAD;
            end
         end
         pwfp_pkg::PH_FIXED: begin
            need = (dec_wire == pwfp_pkg::WIRE_FIXED64) ? 8 : 4;
            dec_acc |= {56'd0, b} << (8 * dec_fix);
            if (dec_fix + 1 >= need) begin
               push_field(dec_acc, last);
               clear_work();
               dec_phase = pwfp_pkg::PH_TAG;
            end else if (last) begin
               push_error(pwfp_pkg::ERR_TRUNCATED, last);
            end else begin
               dec_fix++;
            end
         end
         pwfp_pkg::PH_PAYLOAD: begin
            if (dec_left != 0) dec_left--;
            // a short payload at the end mark gives the error instead of the byte
            if (dec_left != 0 && last) push_error(pwfp_pkg::ERR_TRUNCATED, last);
            else begin
               r = '0;
               r.result_kind = pwfp_pkg::KIND_PAYLOAD;
               r.field_number = dec_field;
               r.wire_type = dec_wire;
               r.payload_byte = b;
               r.payload_last = (dec_left == 0);
               r.message_end = last;
               predicted_results.push_back(r);
               if (dec_left == 0) dec_phase = pwfp_pkg::PH_TAG;
            end
         end
         default: begin
            step = take_varint_group(b);
            if (step == VARINT_OVER) push_error(pwfp_pkg::ERR_OVERLONG, last);
            else if (step == VARINT_MORE) begin
               if (last) push_error(pwfp_pkg::ERR_TRUNCATED, last);
            end else begin
               number = dec_acc[63:3];
               wtype = dec_acc[2:0];
               if (number == 0 || number > FIELD_NUMBER_MAX) begin
                  push_error(pwfp_pkg::ERR_BAD_TAG, last);
               end else if (wtype == pwfp_pkg::WIRE_GROUP_START ||
                            wtype == pwfp_pkg::WIRE_GROUP_END) begin
                  push_error(pwfp_pkg::ERR_GROUP, last);
               end else if (wtype > pwfp_pkg::WIRE_FIXED32) begin
                  push_error(pwfp_pkg::ERR_BAD_TAG, last);
               end else begin
                  dec_field = number[28:0];
                  dec_wire = wtype;
                  clear_work();
                  if (last) push_error(pwfp_pkg::ERR_TRUNCATED, last);
                  else if (wtype == pwfp_pkg::WIRE_VARINT) dec_phase = pwfp_pkg::PH_VALUE;
                  else if (wtype == pwfp_pkg::WIRE_LEN) dec_phase = pwfp_pkg::PH_LEN;
                  else dec_phase = pwfp_pkg::PH_FIXED;
               end
            end
         end
      endcase
   endtask

   // ---------------- message builders ----------------

   function automatic int varint_len(input logic [63:0] v);
      int n;
      n = 1;
      while (n < pwfp_pkg::VARINT_MAX_BYTES && (v >> (7 * n)) != 0) n++;
      return n;
   endfunction

   function automatic int pick_pad(input int len);
      if ($urandom_range(9) == 0 && len < pwfp_pkg::VARINT_MAX_BYTES)
         return $urandom_range(1, pwfp_pkg::VARINT_MAX_BYTES - len);
      return 0;
   endfunction

   // extra groups beyond the minimal length pad the varint, or overrun it
   task automatic add_varint(input logic [63:0] v, input int extra);
      int         n;
      logic [7:0] grp;
      n = varint_len(v) + extra;
      for (int i = 0; i < n; i++) begin
         grp = 8'((v >> (7 * i)) & 64'h7f);
         // tenth group: only bit 0 counts, so stir the rest
         if (i == pwfp_pkg::VARINT_MAX_BYTES - 1 && i == n - 1) grp |= 8'($urandom) & 8'h7e;
         if (i < n - 1) grp |= 8'h80;
         msg_bytes.push_back(grp);
      end
   endtask

   task automatic add_tag(input logic [60:0] number, input logic [2:0] wtype);
      add_varint({number, wtype}, pick_pad(varint_len({number, wtype})));
   endtask

   function automatic logic [60:0] random_field_number();
      int sel;
      sel = $urandom_range(9);
      if (sel == 0) return FIELD_NUMBER_MAX;
      if (sel < 5) return 61'($urandom_range(1, 15));
      return 61'($urandom_range(1, 32'(FIELD_NUMBER_MAX)));
   endfunction

   task automatic add_good_field();
      logic [2:0]  wtype;
      logic [63:0] value;
      bit          short_len;
      case ($urandom_range(3))
         0: wtype = pwfp_pkg::WIRE_VARINT;
         1: wtype = pwfp_pkg::WIRE_FIXED64;
         2: wtype = pwfp_pkg::WIRE_LEN;
         default: wtype = pwfp_pkg::WIRE_FIXED32;
      endcase
      add_tag(random_field_number(), wtype);
      case (wtype)
         pwfp_pkg::WIRE_VARINT: begin
            value = {$urandom, $urandom} >> $urandom_range(64);
            add_varint(value, pick_pad(varint_len(value)));
         end
         pwfp_pkg::WIRE_FIXED64: repeat (8) msg_bytes.push_back(8'($urandom));
         pwfp_pkg::WIRE_FIXED32: repeat (4) msg_bytes.push_back(8'($urandom));
         default: begin
            // now and then a length far past the end of the message
            short_len = ($urandom_range(19) != 0);
            value = short_len ? 64'($urandom_range(5)) :
                    {$urandom, $urandom} >> $urandom_range(63);
            add_varint(value, pick_pad(varint_len(value)));
            if (short_len) repeat (value) msg_bytes.push_back(8'($urandom));
         end
      endcase
   endtask

   task automatic add_bad_field();
      logic [63:0] value;
      case ($urandom_range(5))
         0: add_tag('0, 3'($urandom));
         1: add_tag(FIELD_NUMBER_MAX + 61'd1 +
                    61'({$urandom, $urandom} >> $urandom_range(4, 64)), 3'($urandom));
         2: add_tag(random_field_number(),
                    $urandom_range(1) ? pwfp_pkg::WIRE_GROUP_START : pwfp_pkg::WIRE_GROUP_END);
         3: add_tag(random_field_number(), WIRE_RESERVED7 - 3'($urandom_range(1)));
         4: begin
            add_tag(random_field_number(), pwfp_pkg::WIRE_VARINT);
            value = {$urandom, $urandom};
            add_varint(value, pwfp_pkg::VARINT_MAX_BYTES + 1 - varint_len(value) +
                              $urandom_range(2));
         end
         default: begin
            value = {$urandom, $urandom};
            add_varint(value, pwfp_pkg::VARINT_MAX_BYTES + 1 - varint_len(value) +
                              $urandom_range(2));
         end
      endcase
   endtask

   // move the first keep bytes of the built message to the sender, end mark on the final one
   task automatic queue_bytes(input int keep);
      pwfp_pkg::req_item_type it;
      for (int i = 0; i < keep; i++) begin
         it.in_byte = msg_bytes[i];
         it.last_byte = (i == keep - 1);
         tx_bytes.push_back(it);
         bytes_queued++;
      end
      msg_bytes.delete();
   endtask

   task automatic queue_random_message();
      int roll;
      int nfields;
      int bad_at;
      int cut;
      roll = $urandom_range(99);
      if (roll < 8) begin
         repeat ($urandom_range(1, 6)) msg_bytes.push_back(8'($urandom));
         queue_bytes(msg_bytes.size());
      end else begin
         nfields = $urandom_range(1, 4);
         bad_at = (roll < 25) ? $urandom_range(0, nfields - 1) : -1;
         for (int i = 0; i < nfields; i++) begin
            if (i == bad_at) add_bad_field();
            else add_good_field();
         end
         // chop some messages short to land the end mark mid-field
         cut = (roll >= 25 && roll < 38 && msg_bytes.size() > 1) ?
               $urandom_range(1, msg_bytes.size() - 1) : 0;
         queue_bytes(msg_bytes.size() - cut);
      end
   endtask

   task automatic fill_random(input int unsigned count);
      int unsigned start;
      start = bytes_queued;
      while (bytes_queued - start < count) queue_random_message();
   endtask

   task automatic wait_drained();
      while (bytes_accepted != bytes_queued || predicted_results.size() != 0) @(posedge clock);
   endtask

   // ---------------- checking ----------------

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h got %h", $time, name, want, got);
         fail_count++;
      end
   endtask

   task automatic check_result(input pwfp_pkg::rsp_item_type got);
      pwfp_pkg::rsp_item_type want;
      if (predicted_results.size() == 0) begin
         $display("%0t: result with none expected, got %p", $time, got);
         fail_count++;
      end else begin
         want = predicted_results.pop_front();
         compare_field("result_kind", want.result_kind, got.result_kind);
         compare_field("field_number", want.field_number, got.field_number);
         compare_field("wire_type", want.wire_type, got.wire_type);
         compare_field("field_value", want.field_value, got.field_value);
         compare_field("payload_byte", want.payload_byte, got.payload_byte);
         compare_field("payload_last", want.payload_last, got.payload_last);
         compare_field("error_code", want.error_code, got.error_code);
         compare_field("message_end", want.message_end, got.message_end);
         case (want.result_kind)
            pwfp_pkg::KIND_FIELD: fields_seen++;
            pwfp_pkg::KIND_PAYLOAD: payload_seen++;
            default: errors_seen++;
         endcase
      end
   endtask

   // ---------------- driver ----------------

   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
         req_item <= '0;
      end else begin
         if (req_push && !req_full) begin
            decode_byte(req_item.in_byte, req_item.last_byte);
            bytes_accepted++;
         end
         if (req_push && req_full) begin
            // hold the offered item until the block takes it
            full_cycles++;
         end else if (tx_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_item <= tx_bytes.pop_front();
            req_push <= 1'b1;
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // ---------------- monitor ----------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) check_result(rsp_item);
         if (hold_request && !hold_started) begin
            hold_started = 1'b1;
            hold_left = HOLD_CYCLES;
         end else if (hold_left != 0) begin
            hold_left--;
         end
         rsp_pop <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // ---------------- watchdog ----------------

   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("%0t: no handshake for %0d cycles, %0d results outstanding",
               $time, QUIET_LIMIT, predicted_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // ---------------- stimulus ----------------

   initial begin
      int unsigned send_pcts[4];
      int unsigned recv_pcts[4];
      send_pcts = '{0, 77, 0, 20};
      recv_pcts = '{0, 0, 77, 20};
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // smallest field number, varint zero
      add_tag(61'd1, pwfp_pkg::WIRE_VARINT);
      msg_bytes.push_back(8'h00);
      queue_bytes(msg_bytes.size());
      // largest field number as fixed32, all ones
      add_varint({FIELD_NUMBER_MAX, pwfp_pkg::WIRE_FIXED32}, 0);
      repeat (4) msg_bytes.push_back(8'hff);
      queue_bytes(msg_bytes.size());
      // empty length-delimited field completes at once
      add_varint({61'd2, pwfp_pkg::WIRE_LEN}, 0);
      msg_bytes.push_back(8'h00);
      queue_bytes(msg_bytes.size());
      // two payload bytes
      add_varint({61'd3, pwfp_pkg::WIRE_LEN}, 0);
      msg_bytes.push_back(8'h02);
      msg_bytes.push_back(8'hff);
      msg_bytes.push_back(8'h00);
      queue_bytes(msg_bytes.size());
      // field number zero on the final byte
      add_varint({61'd0, pwfp_pkg::WIRE_VARINT}, 0);
      queue_bytes(msg_bytes.size());
      // group start, then a byte to be dropped
      add_varint({61'd1, pwfp_pkg::WIRE_GROUP_START}, 0);
      msg_bytes.push_back(8'h55);
      queue_bytes(msg_bytes.size());
      // unknown wire type
      add_varint({61'd1, WIRE_RESERVED7}, 0);
      queue_bytes(msg_bytes.size());
      // valid tag with the value cut off
      add_varint({61'd3, pwfp_pkg::WIRE_FIXED64}, 0);
      queue_bytes(msg_bytes.size());
      wait_drained();

      for (int p = 0; p < 4; p++) begin
         send_idle_pct = send_pcts[p];
         recv_stall_pct = recv_pcts[p];
         // first random phase: long receiver hold while bytes keep coming
         if (p == 0) hold_request = 1'b1;
         fill_random(PHASE_BYTES);
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Streamed %0d message bytes: %0d fields, %0d payload bytes, %0d errors checked.",
               bytes_accepted, fields_seen, payload_seen, errors_seen);
      $display("Input held off by a full queue for %0d cycles; %0d mismatches.",
               full_cycles, fail_count);
      if (fail_count == 0 && predicted_results.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
